// ----- design/hex_record_line_parser_assert.svh -----
// Assertion macros for the HEX record line parser.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef HEX_RECORD_LINE_PARSER_ASSERT_SVH
`define HEX_RECORD_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define HRLP_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define HRLP_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/hrlp_pkg.sv -----
// Shared types and codes for the HEX record line parser.
// No dependencies.
package hrlp_pkg;

    // Line framing characters
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Record type codes
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_EMPTY  = 3'd1,
        KIND_EOF    = 3'd2,
        KIND_COLON  = 3'd3,
        KIND_TYPE   = 3'd4,
        KIND_BADHEX = 3'd5
    } kind_t;

    // Input word: one character of the stream
    typedef struct packed {
        logic [7:0] ch;
        logic       start_of_file;
    } in_t;

    // Result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  record_length;
        logic [31:0] record_address;
        logic        last;
    } out_t;

    // Step result handed from the decoder to the top level
    typedef struct packed {
        logic valid;
        out_t res;
    } step_t;

endpackage

// ----- design/hrlp_core.sv -----
// Line decoder state and per-character step logic.
// Depends on hrlp_pkg.
module hrlp_core
    import hrlp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step_en,
    input  in_t   item,
    output step_t step
);

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_DATA,
        PH_EXT,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic [15:0] acc_reg, acc_next;

    logic        is_hex;
    logic [3:0]  nib;
    logic [15:0] high_eff;
    logic [15:0] acc_shift;
    logic [8:0]  count_inc;
    logic [7:0]  pair_count;

    // Decode one hex digit, either case
    always_comb begin
        is_hex = 1'b1;
        nib    = '0;
        if (item.ch >= 8'h30 && item.ch <= 8'h39) begin
            nib = item.ch[3:0];
        end else if ((item.ch >= 8'h41 && item.ch <= 8'h46) ||
                     (item.ch >= 8'h61 && item.ch <= 8'h66)) begin
            nib = item.ch[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign high_eff   = item.start_of_file ? '0 : high_reg;
    assign acc_shift  = {acc_reg[11:0], nib};
    assign count_inc  = count_reg + 9'd1;
    assign pair_count = count_inc[8:1];

    // Advance the line state by one character
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        low_next   = low_reg;
        high_next  = high_eff;
        acc_next   = acc_reg;
        step       = '0;
        step.res.kind = KIND_DATA;

        case (phase_reg)
            PH_START: begin
                if (item.ch == CH_COLON) begin
                    phase_next = PH_HEADER;
                    count_next = '0;
                    acc_next   = '0;
                end else begin
                    if (item.ch != CH_NEWLINE) begin
                        phase_next = PH_SKIP;
                    end
                    step.valid    = 1'b1;
                    step.res.kind = KIND_COLON;
                    step.res.last = 1'b1;
                end
            end
            PH_SKIP: begin
                if (item.ch == CH_NEWLINE) begin
                    phase_next = PH_START;
                end
            end
            PH_HEADER, PH_DATA, PH_EXT: begin
                if (item.ch == CH_NEWLINE || !is_hex) begin
                    // Short line or bad digit
                    phase_next    = (item.ch == CH_NEWLINE) ? PH_START : PH_SKIP;
                    step.valid    = 1'b1;
                    step.res.kind = KIND_BADHEX;
                    step.res.last = 1'b1;
                end else begin
                    acc_next   = acc_shift;
                    count_next = count_inc;
                    if (phase_reg == PH_HEADER) begin
                        if (count_inc == 9'd2) begin
                            len_next = acc_shift[7:0];
                        end else if (count_inc == 9'd6) begin
                            low_next = acc_shift;
                        end else if (count_inc == 9'd8) begin
                            count_next = '0;
                            acc_next   = '0;
                            case (acc_shift[7:0])
                                REC_DATA: begin
                                    if (len_reg == 8'd0) begin
                                        phase_next = PH_SKIP;
                                        step.valid = 1'b1;
                                        step.res.kind = KIND_EMPTY;
                                        step.res.record_address = {high_eff, low_reg};
                                        step.res.last = 1'b1;
                                    end else begin
                                        phase_next = PH_DATA;
                                    end
                                end
                                REC_EOF: begin
                                    phase_next    = PH_SKIP;
                                    step.valid    = 1'b1;
                                    step.res.kind = KIND_EOF;
                                    step.res.last = 1'b1;
                                end
                                REC_EXT: begin
                                    phase_next = PH_EXT;
                                end
                                default: begin
                                    phase_next    = PH_SKIP;
                                    step.valid    = 1'b1;
                                    step.res.kind = KIND_TYPE;
                                    step.res.last = 1'b1;
                                end
                            endcase
                        end
                    end else if (phase_reg == PH_EXT) begin
                        if (count_inc == 9'd4) begin
                            high_next  = acc_shift;
                            phase_next = PH_SKIP;
                        end
                    end else if (!count_inc[0]) begin
                        // Second digit of a pair completes a data byte
                        step.valid = 1'b1;
                        step.res.kind = KIND_DATA;
                        step.res.data_byte = acc_shift[7:0];
                        step.res.byte_index = pair_count - 8'd1;
                        step.res.record_length = len_reg;
                        step.res.record_address = {high_eff, low_reg};
                        step.res.last = (pair_count >= len_reg);
                        if (pair_count >= len_reg) begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            default: begin
                phase_next = (item.ch == CH_NEWLINE) ? PH_START : PH_SKIP;
            end
        endcase
    end

    // Hold state; update only when a word is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            count_reg <= '0;
            len_reg   <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            acc_reg   <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ----- design/hex_record_line_parser.sv -----
// Intel HEX line parser: one ASCII character per input word, at most one
// result word per character. A character is registered, decoded against the
// line state, and its result lands in an output register; the block sustains
// one character per cycle while the output is not stalled, through the input
// register and the output register. A stalled output holds the pipeline only
// once both registers are full.
// Depends on hrlp_pkg, hrlp_core and hex_record_line_parser_assert.svh.
`include "hex_record_line_parser_assert.svh"

module hex_record_line_parser
    import hrlp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic  in_valid_reg;
    in_t   in_data_reg;
    logic  out_valid_reg;
    out_t  out_data_reg;
    logic  out_free;
    logic  step_en;
    step_t step;

    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Input register: take a word when empty or whenever the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    hrlp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_data_reg),
        .step    (step)
    );

    // Result register: load on a step that yields a result, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step_en && step.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step_en && step.valid) begin
            out_data_reg <= step.res;
        end
    end

    `HRLP_ASSERT_IMP(a_nondata_last, m_valid && m_data.kind != KIND_DATA, m_data.last, "non-data result without last")
    `HRLP_ASSERT_IMP(a_nondata_zero, m_valid && m_data.kind != KIND_DATA, m_data.data_byte == 8'd0 && m_data.byte_index == 8'd0, "non-data result with byte fields set")
    `HRLP_ASSERT_IMP(a_data_index, m_valid && m_data.kind == KIND_DATA, m_data.byte_index < m_data.record_length, "data byte index beyond record length")
    `HRLP_ASSERT_NXT(a_stall_holds, in_valid_reg && !out_free, in_valid_reg && $stable(in_data_reg), "held input word lost under stall")

endmodule
